@@ src/cache_entry_manager_lru_lfu_ttl_macros.svh @@
// Assertion macros of the cache entry manager checker.
`ifndef CACHE_ENTRY_MANAGER_LRU_LFU_TTL_MACROS_SVH
`define CACHE_ENTRY_MANAGER_LRU_LFU_TTL_MACROS_SVH

// Same-cycle implication under active-low reset.
`define CEMLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under active-low reset.
`define CEMLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/cemlt_pkg.sv @@
// Shared constants, codes and types of the cache entry manager.
package cemlt_pkg;

    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = IDX_W + 1;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_PURGE  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_LFU = 2'd1;
    localparam logic [1:0] POL_TTL = 2'd2;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_MAX_BYTES = 2'd1;
    localparam logic [1:0] REG_MAX_ELEM  = 2'd2;
    localparam logic [1:0] REG_DEF_TTL   = 2'd3;

    localparam logic [3:0] ST_HIT       = 4'd0;
    localparam logic [3:0] ST_MISS      = 4'd1;
    localparam logic [3:0] ST_EXPIRED   = 4'd2;
    localparam logic [3:0] ST_ADDED     = 4'd3;
    localparam logic [3:0] ST_TOO_LARGE = 4'd4;
    localparam logic [3:0] ST_NO_ROOM   = 4'd5;
    localparam logic [3:0] ST_PURGED    = 4'd6;
    localparam logic [3:0] ST_NOT_FOUND = 4'd7;
    localparam logic [3:0] ST_CLEARED   = 4'd8;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [23:0]         size;
        logic [31:0]         expiry;
        logic [31:0]         hits;
        logic [31:0]         order;
    } t_rec;

endpackage

@@ src/cemlt_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module cemlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cache_entry_manager_lru_lfu_ttl.sv @@
// Cache entry table with LRU, LFU and TTL replacement: top level.
//
//  channel  | direction | contents
//  s_axis   | in        | tuser mode; tdata key, element bytes, max age, now
//  m_axis   | out       | tuser status; tdata slot, hit count, evicted, bytes used
//  apb      | in/out    | policy, byte budget, max element bytes, default ttl
//
// Clear and too-large adds skip the key search.
// Lookup and purge search the entry RAM for the key, one slot per cycle.
// Add runs the same key search, then one full scan of the entry RAM per evicted victim.
// Reset clears the valid flags at once; no clearing pass is needed.
// A result held by the receiver stalls the block in its done state and holds off input.
module cache_entry_manager_lru_lfu_ttl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // key[31:0] bytes[55:32] max_age[79:56] now[111:80]
    input  logic [1:0]   s_axis_tuser,  // mode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,  // slot[5:0] hits[37:6] evicted[44:38] bytes[76:45]
    output logic [3:0]   m_axis_tuser,  // status[3:0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int N     = cemlt_pkg::ENTRIES;
    localparam int IDX_W = cemlt_pkg::IDX_W;
    localparam int CNT_W = cemlt_pkg::CNT_W;

    typedef enum logic [2:0] {S_IDLE, S_FIND, S_FIT, S_VICT, S_DONE} t_state;

    t_state r_state;
    logic [N-1:0]       r_valid;
    logic [CNT_W-1:0]   r_idx;
    logic               r_chk;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_best_v;
    logic [IDX_W-1:0]   r_best_idx;
    cemlt_pkg::t_rec    r_best;
    logic [1:0]         r_policy;
    logic [31:0]        r_max_bytes;
    logic [23:0]        r_max_elem;
    logic [23:0]        r_def_ttl;
    logic [1:0]         r_mode;
    logic [cemlt_pkg::KEY_BITS-1:0] r_key;
    logic [23:0]        r_size;
    logic [23:0]        r_age;
    logic [31:0]        r_now;
    logic [31:0]        r_counter;
    logic [31:0]        r_bytes;
    logic [3:0]         r_res_status;
    logic [IDX_W-1:0]   r_res_slot;
    logic [31:0]        r_res_hits;
    logic [CNT_W-1:0]   r_evict;
    logic               r_out_valid;
    logic [3:0]         r_out_user;
    logic [79:0]        r_out_data;

    cemlt_pkg::t_rec rd_data;
    cemlt_pkg::t_rec wdata;
    logic            we;
    logic [IDX_W-1:0] waddr;
    logic            match;
    logic            scan_end;
    logic            over;
    logic            free_v;
    logic [IDX_W-1:0] free_idx;
    logic            expired;
    logic [31:0]     hits_inc;
    logic [31:0]     age_i;
    logic [31:0]     age_b;
    logic            better;
    logic [23:0]     lifetime;
    logic            in_acc;
    logic            cfg_wr;

    cemlt_ram #(
        .WIDTH ($bits(cemlt_pkg::t_rec)),
        .DEPTH (N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign pready   = 1'b1;
    assign match    = r_chk && r_valid[r_chk_idx] && (rd_data.key == r_key);
    assign scan_end = (r_idx == CNT_W'(N));
    assign over     = ({1'b0, r_bytes} + 33'(r_size)) > {1'b0, r_max_bytes};
    assign expired  = (rd_data.expiry != 32'd0) && (rd_data.expiry < r_now);
    assign hits_inc = (rd_data.hits == 32'hFFFF_FFFF) ? rd_data.hits : rd_data.hits + 32'd1;
    assign age_i    = r_counter - rd_data.order;
    assign age_b    = r_counter - r_best.order;
    assign lifetime = (r_age != 24'd0) ? r_age : r_def_ttl;

    always_comb begin
        case (r_policy)
            cemlt_pkg::POL_LFU: better = (rd_data.hits < r_best.hits) ||
                ((rd_data.hits == r_best.hits) && (age_i > age_b));
            cemlt_pkg::POL_TTL: better = (rd_data.expiry < r_best.expiry) ||
                ((rd_data.expiry == r_best.expiry) && (age_i > age_b));
            default: better = age_i > age_b;
        endcase
    end

    always_comb begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_v   = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_chk_idx;
        wdata = rd_data;
        if (r_state == S_FIND && match && r_mode == cemlt_pkg::MODE_LOOKUP && !expired) begin
            we         = 1'b1;
            wdata.hits = hits_inc;
            if (r_policy == cemlt_pkg::POL_LRU) begin
                wdata.order = r_counter;
            end
        end else if (r_state == S_FIT && !over && free_v) begin
            we           = 1'b1;
            waddr        = free_idx;
            wdata.key    = r_key;
            wdata.size   = r_size;
            wdata.expiry = r_now + {8'd0, lifetime};
            wdata.hits   = 32'd1;
            wdata.order  = r_counter;
        end
    end

    always_comb begin
        case (paddr[3:2])
            cemlt_pkg::REG_POLICY:    prdata = {30'd0, r_policy};
            cemlt_pkg::REG_MAX_BYTES: prdata = r_max_bytes;
            cemlt_pkg::REG_MAX_ELEM:  prdata = {8'd0, r_max_elem};
            cemlt_pkg::REG_DEF_TTL:   prdata = {8'd0, r_def_ttl};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_chk       <= 1'b0;
            r_best_v    <= 1'b0;
            r_counter   <= 32'd0;
            r_bytes     <= 32'd0;
            r_out_valid <= 1'b0;
            r_policy    <= 2'd0;
            r_max_bytes <= 32'd16777216;
            r_max_elem  <= 24'd1048576;
            r_def_ttl   <= 24'd3600;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    cemlt_pkg::REG_POLICY:    r_policy    <= pwdata[1:0];
                    cemlt_pkg::REG_MAX_BYTES: r_max_bytes <= pwdata;
                    cemlt_pkg::REG_MAX_ELEM:  r_max_elem  <= pwdata[23:0];
                    cemlt_pkg::REG_DEF_TTL:   r_def_ttl   <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode     <= s_axis_tuser;
                        r_key      <= s_axis_tdata[cemlt_pkg::KEY_BITS-1:0];
                        r_size     <= s_axis_tdata[55:32];
                        r_age      <= s_axis_tdata[79:56];
                        r_now      <= s_axis_tdata[111:80];
                        r_res_slot <= '0;
                        r_res_hits <= 32'd0;
                        r_evict    <= '0;
                        r_idx      <= '0;
                        r_chk      <= 1'b0;
                        if (s_axis_tuser == cemlt_pkg::MODE_CLEAR) begin
                            r_valid      <= '0;
                            r_bytes      <= 32'd0;
                            r_res_status <= cemlt_pkg::ST_CLEARED;
                            r_state      <= S_DONE;
                        end else if (s_axis_tuser == cemlt_pkg::MODE_ADD &&
                                     s_axis_tdata[55:32] > r_max_elem) begin
                            r_res_status <= cemlt_pkg::ST_TOO_LARGE;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (match) begin
                        r_chk <= 1'b0;
                        case (r_mode)
                            cemlt_pkg::MODE_LOOKUP: begin
                                if (expired) begin
                                    r_valid[r_chk_idx] <= 1'b0;
                                    r_bytes      <= r_bytes - 32'(rd_data.size);
                                    r_res_status <= cemlt_pkg::ST_EXPIRED;
                                end else begin
                                    r_res_status <= cemlt_pkg::ST_HIT;
                                    r_res_slot   <= r_chk_idx;
                                    r_res_hits   <= hits_inc;
                                    if (r_policy == cemlt_pkg::POL_LRU) begin
                                        r_counter <= r_counter + 32'd1;
                                    end
                                end
                                r_state <= S_DONE;
                            end
                            cemlt_pkg::MODE_PURGE: begin
                                r_valid[r_chk_idx] <= 1'b0;
                                r_bytes      <= r_bytes - 32'(rd_data.size);
                                r_res_status <= cemlt_pkg::ST_PURGED;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_valid[r_chk_idx] <= 1'b0;
                                r_bytes <= r_bytes - 32'(rd_data.size);
                                r_state <= S_FIT;
                            end
                        endcase
                    end else if (scan_end) begin
                        r_chk <= 1'b0;
                        case (r_mode)
                            cemlt_pkg::MODE_LOOKUP: begin
                                r_res_status <= cemlt_pkg::ST_MISS;
                                r_state      <= S_DONE;
                            end
                            cemlt_pkg::MODE_PURGE: begin
                                r_res_status <= cemlt_pkg::ST_NOT_FOUND;
                                r_state      <= S_DONE;
                            end
                            default: r_state <= S_FIT;
                        endcase
                    end else begin
                        r_chk     <= 1'b1;
                        r_chk_idx <= r_idx[IDX_W-1:0];
                        r_idx     <= r_idx + CNT_W'(1);
                    end
                end
                S_FIT: begin
                    if (!over && free_v) begin
                        r_valid[free_idx] <= 1'b1;
                        r_counter    <= r_counter + 32'd1;
                        r_bytes      <= r_bytes + 32'(r_size);
                        r_res_status <= cemlt_pkg::ST_ADDED;
                        r_res_slot   <= free_idx;
                        r_state      <= S_DONE;
                    end else if (r_valid == '0) begin
                        r_res_status <= cemlt_pkg::ST_NO_ROOM;
                        r_state      <= S_DONE;
                    end else begin
                        r_idx    <= '0;
                        r_chk    <= 1'b0;
                        r_best_v <= 1'b0;
                        r_state  <= S_VICT;
                    end
                end
                S_VICT: begin
                    if (r_chk && r_valid[r_chk_idx] && (!r_best_v || better)) begin
                        r_best     <= rd_data;
                        r_best_idx <= r_chk_idx;
                        r_best_v   <= 1'b1;
                    end
                    if (scan_end && !r_chk) begin
                        r_valid[r_best_idx] <= 1'b0;
                        r_bytes <= r_bytes - 32'(r_best.size);
                        r_evict <= r_evict + CNT_W'(1);
                        r_state <= S_FIT;
                    end else if (scan_end) begin
                        r_chk <= 1'b0;
                    end else begin
                        r_chk     <= 1'b1;
                        r_chk_idx <= r_idx[IDX_W-1:0];
                        r_idx     <= r_idx + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_res_status;
                        r_out_data  <= {3'd0, r_bytes, 7'(r_evict), r_res_hits, 6'(r_res_slot)};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ src/cemlt_checker.sv @@
// Port-level checker of the cache entry manager and its bind.
`include "cache_entry_manager_lru_lfu_ttl_macros.svh"

module cemlt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata,
    input logic [3:0]   m_axis_tuser
);

    `CEMLT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CEMLT_ASSERT_NOW(a_hits_only_on_hit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != cemlt_pkg::ST_HIT, m_axis_tdata[37:6] == 32'd0)
    `CEMLT_ASSERT_NOW(a_clear_empties, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == cemlt_pkg::ST_CLEARED, m_axis_tdata[76:45] == 32'd0)
    `CEMLT_ASSERT_NOW(a_no_evict_lookup, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == cemlt_pkg::ST_MISS || m_axis_tuser == cemlt_pkg::ST_TOO_LARGE || m_axis_tuser == cemlt_pkg::ST_NOT_FOUND), m_axis_tdata[44:0] == 45'd0)
    `CEMLT_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind cache_entry_manager_lru_lfu_ttl cemlt_checker u_cemlt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
